// ----- sv/rbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rbc_pkg: shared types and codes for the reorder buffer commit core
// Holds the operation codes, entry states and the item and result structs.
// ----------------------------------------------------------------------------
package rbc_pkg;

   // Transaction modes
   localparam logic [1:0] MODE_DISPATCH = 2'd0;
   localparam logic [1:0] MODE_COMPLETE = 2'd1;
   localparam logic [1:0] MODE_COMMIT   = 2'd2;
   localparam logic [1:0] MODE_FLUSH    = 2'd3;

   // Op classes
   localparam logic [2:0] OPC_REG    = 3'd0;
   localparam logic [2:0] OPC_JUMP   = 3'd1;
   localparam logic [2:0] OPC_BRANCH = 3'd2;
   localparam logic [2:0] OPC_STB    = 3'd3;
   localparam logic [2:0] OPC_STH    = 3'd4;
   localparam logic [2:0] OPC_STW    = 3'd5;
   localparam logic [2:0] OPC_RET    = 3'd6;

   // Entry states
   localparam logic [1:0] ST_WAIT  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;

   localparam int REQ_BYTES = 14;
   localparam int RSP_BYTES = 19;

   typedef struct packed {
      logic [31:0] value_two;
      logic [31:0] value_one;
      logic [4:0]  entry_tag;
      logic        predicted_taken;
      logic [31:0] inst_pc;
      logic [4:0]  dest_reg;
      logic [2:0]  op_class;
      logic [1:0]  mode;
   } item_type;

   typedef struct packed {
      logic [4:0]  status_flags;
      logic [1:0]  store_size;
      logic [31:0] store_data;
      logic [31:0] store_addr;
      logic        store_valid;
      logic        mispredicted;
      logic [31:0] redirect_pc;
      logic        redirect_valid;
      logic [4:0]  slot_tag;
      logic [31:0] write_value;
      logic [4:0]  write_reg;
      logic        reg_write_valid;
   } result_type;

endpackage

// ----- sv/rbc_ram.sv -----
// ----------------------------------------------------------------------------
// rbc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- sv/rbc_front.sv -----
// ----------------------------------------------------------------------------
// rbc_front: input stage with a two-entry queue
// Accepts transactions and holds them until the back end takes one.
// ----------------------------------------------------------------------------
module rbc_front
   import rbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_take,
   output item_type q_item
);

   item_type   slot_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_take;
   assign q_item   = slot_ff[rd_ptr_ff];

   // queue pointers and storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- sv/rbc_back.sv -----
// ----------------------------------------------------------------------------
// rbc_back: reorder buffer and predictor execution engine
// Runs one queued transaction through a small sequencer: read, then act.
// ----------------------------------------------------------------------------
module rbc_back
   import rbc_pkg::*;
#(
   parameter int ROB_DEPTH       = 32,
   parameter int HISTORY_ENTRIES = 1024,
   parameter int HISTORY_BITS    = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_take,
   input  item_type   q_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   localparam int RW  = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
   localparam int OW  = $clog2(ROB_DEPTH + 1);
   localparam int HW  = $clog2(HISTORY_ENTRIES);
   localparam int CW  = HW + HISTORY_BITS;
   localparam int CNT = HISTORY_ENTRIES << HISTORY_BITS;
   localparam int CLR = (CW > HW) ? CW : HW;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_TRAIN, S_OUT} state_type;

   state_type      state_ff;
   item_type       item_ff;
   logic [RW-1:0]  head_ff, tail_ff;
   logic [OW-1:0]  occ_ff;
   logic [1:0]     cd_ff;
   logic           fin_ff, jmp_ff, brs_ff;
   logic [CLR:0]   clr_ff;
   result_type     res_ff;
   logic           res_vld_ff;

   // entry memories
   logic           info_we, pc_we, val_we;
   logic [RW-1:0]  info_wa, info_ra;
   logic [10:0]    info_wd, info_rd;
   logic [31:0]    pc_rd, v1_rd, v2_rd;
   logic [RW-1:0]  val_wa;
   logic [31:0]    v1_wd, v2_wd;

   // predictor memories
   logic                    hist_we, ctr_we;
   logic [HW-1:0]           hist_wa, hist_ra;
   logic [HISTORY_BITS-1:0] hist_wd, hist_rd;
   logic [CW-1:0]           ctr_wa, ctr_ra;
   logic [1:0]              ctr_wd, ctr_rd;
   logic                    taken_ff;
   logic [HW-1:0]           hidx_ff;

   rbc_ram #(.WIDTH(11), .DEPTH(ROB_DEPTH)) u_info (
      .clock, .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(info_ra), .rd_data(info_rd));
   rbc_ram #(.WIDTH(32), .DEPTH(ROB_DEPTH)) u_pc (
      .clock, .wr_en(pc_we), .wr_addr(tail_ff), .wr_data(item_ff.inst_pc),
      .rd_addr(head_ff), .rd_data(pc_rd));
   rbc_ram #(.WIDTH(32), .DEPTH(ROB_DEPTH)) u_v1 (
      .clock, .wr_en(val_we), .wr_addr(val_wa), .wr_data(v1_wd),
      .rd_addr(head_ff), .rd_data(v1_rd));
   rbc_ram #(.WIDTH(32), .DEPTH(ROB_DEPTH)) u_v2 (
      .clock, .wr_en(val_we), .wr_addr(val_wa), .wr_data(v2_wd),
      .rd_addr(head_ff), .rd_data(v2_rd));
   rbc_ram #(.WIDTH(HISTORY_BITS), .DEPTH(HISTORY_ENTRIES)) u_hist (
      .clock, .wr_en(hist_we), .wr_addr(hist_wa), .wr_data(hist_wd),
      .rd_addr(hist_ra), .rd_data(hist_rd));
   rbc_ram #(.WIDTH(2), .DEPTH(CNT)) u_ctr (
      .clock, .wr_en(ctr_we), .wr_addr(ctr_wa), .wr_data(ctr_wd),
      .rd_addr(ctr_ra), .rd_data(ctr_rd));

   // decoded views of the current transaction
   logic [RW-1:0] tag_idx;
   logic          tag_ok, occupied, full;
   logic [RW-1:0] tag_dist;
   logic [2:0]    cls;
   logic [1:0]    est;
   logic          taken, is_store;
   logic          commit_branch;
   result_type    res_in;

   assign tag_idx  = RW'(item_ff.entry_tag);
   assign tag_ok   = ({27'd0, item_ff.entry_tag} < ROB_DEPTH);
   // distance from head, wrapping around the buffer
   assign tag_dist = (tag_idx >= head_ff) ? tag_idx - head_ff
                                          : tag_idx + RW'(ROB_DEPTH) - head_ff;
   assign occupied = ({{(32-RW){1'b0}}, tag_dist} < {{(32-OW){1'b0}}, occ_ff});
   assign full     = (occ_ff == OW'(ROB_DEPTH));
   assign cls      = info_rd[2:0];
   assign est      = info_rd[10:9];
   assign taken    = (v1_rd != 32'd0);
   assign is_store = (cls == OPC_STB) || (cls == OPC_STH) || (cls == OPC_STW);
   assign commit_branch = (item_ff.mode == MODE_COMMIT) && (occ_ff != '0) &&
                          (est == ST_READY) && (cls == OPC_BRANCH);

   assign q_take    = (state_ff == S_IDLE) && !res_vld_ff;
   assign out_valid = res_vld_ff;
   assign out_result = res_ff;

   function automatic logic [RW-1:0] next_idx(input logic [RW-1:0] v);
      next_idx = (v == RW'(ROB_DEPTH - 1)) ? '0 : v + 1'b1;
   endfunction

   // memory port control
   always_comb begin
      info_we = 1'b0; info_wa = tail_ff; info_wd = '0;
      info_ra = head_ff;
      pc_we = 1'b0; val_we = 1'b0; val_wa = tail_ff;
      v1_wd = '0; v2_wd = '0;
      hist_we = 1'b0; hist_wa = hidx_ff; hist_wd = '0;
      hist_ra = hidx_ff;
      ctr_we = 1'b0; ctr_wa = {hidx_ff, hist_rd}; ctr_wd = '0;
      ctr_ra = {hidx_ff, hist_rd};
      if (state_ff == S_CLEAR) begin
         hist_we = !clr_ff[CLR]; hist_wa = clr_ff[HW-1:0];
         ctr_we  = !clr_ff[CLR]; ctr_wa  = clr_ff[CW-1:0];
      end else if (state_ff == S_IDLE) begin
         info_ra = (q_item.mode == MODE_COMPLETE) ? RW'(q_item.entry_tag) : head_ff;
         // history of the head entry's pc, ready for a branch commit
         hist_ra = pc_rd[HW-1:0];
      end else if (state_ff == S_READ) begin
         info_ra = (item_ff.mode == MODE_COMPLETE) ? tag_idx : head_ff;
         unique case (item_ff.mode)
            MODE_DISPATCH: begin
               if (!full) begin
                  info_we = 1'b1;
                  info_wd = {ST_WAIT, item_ff.predicted_taken, item_ff.dest_reg,
                             item_ff.op_class};
                  pc_we = 1'b1; val_we = 1'b1;
               end
            end
            MODE_COMPLETE: begin
               if (tag_ok && occupied && est != ST_BUSY) begin
                  info_we = 1'b1; info_wa = tag_idx;
                  info_wd = {ST_READY, info_rd[8:0]};
                  val_we = 1'b1; val_wa = tag_idx;
                  v1_wd = item_ff.value_one; v2_wd = item_ff.value_two;
               end
            end
            MODE_COMMIT: begin
               if (occ_ff != '0 && est == ST_READY && is_store) begin
                  info_we = 1'b1; info_wa = head_ff;
                  info_wd = {ST_BUSY, info_rd[8:0]};
               end
            end
            default: ;
         endcase
      end else if (state_ff == S_TRAIN) begin
         ctr_we = 1'b1;
         if (taken_ff) ctr_wd = (ctr_rd == 2'd3) ? 2'd3 : ctr_rd + 2'd1;
         else          ctr_wd = (ctr_rd == 2'd0) ? 2'd0 : ctr_rd - 2'd1;
         hist_we = 1'b1;
         hist_wd = HISTORY_BITS'({hist_rd, taken_ff});
      end
   end

   // response fields of the current transaction
   always_comb begin
      res_in = '0;
      case (item_ff.mode)
         MODE_DISPATCH: begin
            if (full) res_in.status_flags[4] = 1'b1;
            else      res_in.slot_tag = 5'(tail_ff);
         end
         MODE_COMMIT: begin
            if (occ_ff != '0 && est == ST_READY) begin
               if (cls == OPC_BRANCH) begin
                  if (taken != info_rd[8]) begin
                     res_in.redirect_valid = 1'b1;
                     res_in.redirect_pc    = taken ? v2_rd : pc_rd + 32'd4;
                     res_in.mispredicted   = 1'b1;
                  end
                  res_in.slot_tag = 5'(head_ff);
               end else if (cls == OPC_RET) begin
                  res_in.slot_tag = 5'(head_ff);
               end else if (!is_store) begin
                  res_in.reg_write_valid = 1'b1;
                  res_in.write_reg       = info_rd[7:3];
                  res_in.write_value     = v1_rd;
                  res_in.slot_tag        = 5'(head_ff);
                  if (cls == OPC_JUMP) begin
                     res_in.redirect_valid = 1'b1;
                     res_in.redirect_pc    = v2_rd;
                  end
               end
            end else if (occ_ff != '0 && est == ST_BUSY && cd_ff == 2'd0) begin
               res_in.store_valid = 1'b1;
               res_in.store_addr  = v2_rd;
               res_in.store_data  = v1_rd;
               res_in.store_size  = is_store ? cls[1:0] - 2'd3 : 2'd2;
               res_in.slot_tag    = 5'(head_ff);
            end
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
         cd_ff      <= '0;
         fin_ff     <= 1'b0;
         jmp_ff     <= 1'b0;
         brs_ff     <= 1'b0;
         clr_ff     <= '0;
         res_vld_ff <= 1'b0;
      end else begin
         if (res_vld_ff && out_ready) res_vld_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff[CLR]) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid && q_take) begin
                  item_ff  <= q_item;
                  hidx_ff  <= pc_rd[HW-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               res_ff   <= res_in;
               state_ff <= commit_branch ? S_TRAIN : S_OUT;
               unique case (item_ff.mode)
                  MODE_DISPATCH: begin
                     if (!full) begin
                        tail_ff <= next_idx(tail_ff);
                        occ_ff  <= occ_ff + 1'b1;
                        if (item_ff.op_class == OPC_BRANCH) brs_ff <= 1'b1;
                        else if (item_ff.op_class == OPC_JUMP) jmp_ff <= 1'b1;
                     end
                  end
                  MODE_COMPLETE: ;
                  MODE_COMMIT: begin
                     if (occ_ff != '0 && est == ST_READY) begin
                        if (cls == OPC_BRANCH) begin
                           taken_ff <= taken;
                           head_ff  <= next_idx(head_ff);
                           occ_ff   <= occ_ff - 1'b1;
                        end else if (is_store) begin
                           cd_ff <= 2'd2;
                        end else if (cls == OPC_RET) begin
                           fin_ff  <= 1'b1;
                           head_ff <= next_idx(head_ff);
                           occ_ff  <= occ_ff - 1'b1;
                        end else begin
                           if (cls == OPC_JUMP) jmp_ff <= 1'b0;
                           head_ff <= next_idx(head_ff);
                           occ_ff  <= occ_ff - 1'b1;
                        end
                     end else if (occ_ff != '0 && est == ST_BUSY) begin
                        if (cd_ff != 2'd0) begin
                           cd_ff <= cd_ff - 2'd1;
                        end else begin
                           head_ff <= next_idx(head_ff);
                           occ_ff  <= occ_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     head_ff <= '0;
                     tail_ff <= '0;
                     occ_ff  <= '0;
                     cd_ff   <= '0;
                     fin_ff  <= 1'b0;
                     jmp_ff  <= 1'b0;
                     brs_ff  <= 1'b0;
                  end
               endcase
            end
            S_TRAIN: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // status reflects state after the transaction
               res_ff.status_flags[3:0] <= {brs_ff, jmp_ff, fin_ff,
                                            occ_ff == OW'(ROB_DEPTH)};
               res_vld_ff <= 1'b1;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- sv/reorder_buffer_commit_core.sv -----
// ----------------------------------------------------------------------------
// reorder_buffer_commit_core: reorder buffer with local branch predictor
// Front queue accepts transactions; back end executes them in order.
// ----------------------------------------------------------------------------
// channel | direction | contents
// req     | in        | mode, op_class, dest_reg, inst_pc, ..., value_two
// rsp     | out       | write, tag, redirect, store and status fields
//
// Each transaction passes through the back end's idle, read and output states;
// a committed branch also passes through a train state, which writes back the
// predictor counter and history. After reset, a clearing pass zeroes the
// predictor tables; no transaction executes meanwhile. A two-entry front queue
// keeps req accepting while rsp is stalled, until both of its entries are filled.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_core
   import rbc_pkg::*;
#(
   parameter int ROB_DEPTH       = 32,
   parameter int HISTORY_ENTRIES = 1024,
   parameter int HISTORY_BITS    = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode, op_class, dest_reg, inst_pc, predicted_taken, entry_tag,
   // value_one, value_two (low to high), zero filled
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // reg_write_valid, write_reg, write_value, slot_tag, redirect_valid,
   // redirect_pc, mispredicted, store_valid, store_addr, store_data,
   // store_size, status_flags (low to high), zero filled
   output logic [RSP_BYTES*8-1:0] rsp_tdata
);

   item_type   q_item;
   logic       q_valid, q_take;
   result_type res;

   rbc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(req_tdata[$bits(item_type)-1:0]),
      .q_valid, .q_take, .q_item);

   rbc_back #(
      .ROB_DEPTH(ROB_DEPTH), .HISTORY_ENTRIES(HISTORY_ENTRIES),
      .HISTORY_BITS(HISTORY_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res));

   assign rsp_tdata = {{(RSP_BYTES*8-$bits(result_type)){1'b0}}, res};

endmodule
